[rtl/core/cbw_pkg.sv]
// ----------------------------------------------------------------------------
// cbw_pkg
// Types and constants shared by the cone-beam detector weight block.
// ----------------------------------------------------------------------------
package cbw_pkg;

    localparam int COORD_W   = 32;
    localparam int SLOT_W    = 4;
    localparam int NUM_SLOTS = 12;
    localparam int PIX_W     = 12;
    localparam int DET_W     = 13;
    localparam int MAG_W     = 48;
    localparam int ACC_W     = 96;
    localparam int REM_W     = 100;
    localparam int QUO_W     = 64;

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    // Base slots of the four geometry vectors.
    localparam logic [SLOT_W-1:0] SLOT_SRC = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_DET = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_COL = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_ROW = 4'd9;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    localparam logic [1:0] CFG_DET_ROWS = 2'd0;
    localparam logic [1:0] CFG_DET_COLS = 2'd1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_YMUL   = 7'b0000010,
        ST_SQ     = 7'b0000100,
        ST_CHECK  = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_SQRT   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    typedef struct packed {
        logic                en;
        logic [SLOT_W-1:0]   slot;
        logic [COORD_W-1:0]  value;
    } geom_wr_t;

endpackage

[rtl/core/cbw_store.sv]
// ----------------------------------------------------------------------------
// cbw_store
// Twelve-entry geometry register file with one write and one read port.
// ----------------------------------------------------------------------------
module cbw_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cbw_pkg::geom_wr_t             wr,
    input  logic [cbw_pkg::SLOT_W-1:0]    rd_addr,
    output logic [cbw_pkg::COORD_W-1:0]   rd_data
);

    logic [cbw_pkg::COORD_W-1:0] mem_reg [cbw_pkg::NUM_SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cbw_pkg::NUM_SLOTS; i++) begin
                mem_reg[i] <= '0;
            end
        end else if (wr.en && (wr.slot < cbw_pkg::SLOT_W'(cbw_pkg::NUM_SLOTS))) begin
            mem_reg[wr.slot] <= wr.value;
        end
    end

    assign rd_data = (rd_addr < cbw_pkg::SLOT_W'(cbw_pkg::NUM_SLOTS)) ? mem_reg[rd_addr] : '0;

endmodule

[rtl/core/cbw_mul.sv]
// ----------------------------------------------------------------------------
// cbw_mul
// Shared 32 by 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cbw_mul (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    assign prod = prod_reg;

endmodule

[rtl/core/cone_beam_detector_weight_top.sv]
// ----------------------------------------------------------------------------
// cone_beam_detector_weight_top
// FDK cosine pre-weight engine for one cone-beam projection.
// ----------------------------------------------------------------------------
// Load requests (tuser action 0) write one Q16.16 geometry component
// without leaving the idle state, so loads can follow each other back to
// back. A pixel request (action 1) returns one result: weight = floor(2^30 *
// |d-s| / |y-s|) as unsigned Q2.30, with y the pixel position
// d + row*t2 + col*t1. For each axis in turn, one shared 32x32 multiplier
// first forms the pixel position and then the squared lengths. Then come a
// compare, the restoring division and the bitwise square root, both on one
// shared wide subtractor, and a finish step that moves the result into the
// output register. A saturated pixel skips the division and the root, and
// an out-of-range pixel goes from acceptance straight to the finish step.
// The input is not ready while a pixel is in work. A finished result waits
// in an output register, so the next request is accepted while the previous
// result is still pending; a new result is only handed over once that
// register is free or being read in that cycle.
// ----------------------------------------------------------------------------
module cone_beam_detector_weight_top #(
    parameter int MAX_DET_SIZE = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Slave request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: component[3:0], coord_value[35:4], pixel_row[47:36],
    //        pixel_col[59:48], zero fill[63:60]
    input  logic [63:0] s_tdata,
    // tuser: action[0]
    input  logic [0:0]  s_tuser,
    // Master result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: weight[31:0]
    output logic [31:0] m_tdata,
    // tuser: saturated[0], out_of_range[1]
    output logic [1:0]  m_tuser,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int LIM_W = $clog2(MAX_DET_SIZE + 1);
    localparam int CMP_W = (LIM_W > cbw_pkg::DET_W) ? LIM_W : cbw_pkg::DET_W;

    cbw_pkg::state_t state_reg;

    logic [5:0]  step_reg;
    logic [1:0]  axis_reg;
    logic [cbw_pkg::PIX_W-1:0] row_reg, col_reg;
    logic        sign_reg;
    logic signed [cbw_pkg::MAG_W-1:0] yacc_reg;
    logic signed [cbw_pkg::COORD_W-1:0] dval_reg;
    logic [cbw_pkg::MAG_W-1:0] maga_reg, magb_reg;
    logic [cbw_pkg::ACC_W-1:0] a_reg, b_reg;
    logic [cbw_pkg::REM_W-1:0] rem_reg, den_reg;
    logic [cbw_pkg::QUO_W-1:0] quo_reg, res_reg, bit_reg;
    logic [31:0] rwt_reg, wt_reg;
    logic        rsat_reg, roor_reg, sat_reg, oor_reg, m_tvalid_reg;
    logic [cbw_pkg::DET_W-1:0] det_rows_reg, det_cols_reg;

    // Request fields.
    logic                         in_act;
    logic [cbw_pkg::SLOT_W-1:0]   in_comp;
    logic [cbw_pkg::COORD_W-1:0]  in_coord;
    logic [cbw_pkg::PIX_W-1:0]    in_row, in_col;
    logic                         s_acc;

    assign in_act   = s_tuser[0];
    assign in_comp  = s_tdata[3:0];
    assign in_coord = s_tdata[35:4];
    assign in_row   = s_tdata[47:36];
    assign in_col   = s_tdata[59:48];

    assign s_tready = (state_reg == cbw_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Geometry store: loads write straight from the request.
    cbw_pkg::geom_wr_t           st_wr;
    logic [cbw_pkg::SLOT_W-1:0]  rd_addr;
    logic [cbw_pkg::COORD_W-1:0] rd_data;

    assign st_wr.en    = s_acc && (in_act == cbw_pkg::ACT_LOAD);
    assign st_wr.slot  = in_comp;
    assign st_wr.value = in_coord;

    cbw_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (st_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Read address follows the position sub-step: row step, column step,
    // detector origin, then source, all for the current axis.
    always_comb begin
        case (step_reg[1:0])
            2'd0:    rd_addr = cbw_pkg::SLOT_ROW + cbw_pkg::SLOT_W'(axis_reg);
            2'd1:    rd_addr = cbw_pkg::SLOT_COL + cbw_pkg::SLOT_W'(axis_reg);
            2'd2:    rd_addr = cbw_pkg::SLOT_DET + cbw_pkg::SLOT_W'(axis_reg);
            default: rd_addr = cbw_pkg::SLOT_SRC + cbw_pkg::SLOT_W'(axis_reg);
        endcase
    end

    // Range check against min(register, MAX_DET_SIZE).
    logic [CMP_W-1:0] lim_r, lim_c;
    logic             out_rng;

    always_comb begin
        lim_r = (CMP_W'(det_rows_reg) < CMP_W'(MAX_DET_SIZE)) ? CMP_W'(det_rows_reg)
                                                               : CMP_W'(MAX_DET_SIZE);
        lim_c = (CMP_W'(det_cols_reg) < CMP_W'(MAX_DET_SIZE)) ? CMP_W'(det_cols_reg)
                                                               : CMP_W'(MAX_DET_SIZE);
        out_rng = (CMP_W'(in_row) >= lim_r) || (CMP_W'(in_col) >= lim_c);
    end

    // Shared multiplier operands.
    logic [31:0] mul_a, mul_b, rd_mag;
    logic [63:0] prod;
    logic [cbw_pkg::MAG_W-1:0] sq_src;
    logic [1:0]  iss_term, acc_term;
    logic        acc_to_b, acc_en;

    assign rd_mag = rd_data[31] ? (32'd0 - rd_data) : rd_data;

    // Squaring schedule: the three partial products of |d-s| go to A, then
    // the three of |y-s| go to B, each accumulated in the cycle after its issue.
    always_comb begin
        iss_term = 2'd0;
        acc_term = 2'd0;
        acc_to_b = 1'b0;
        acc_en   = 1'b1;
        sq_src   = maga_reg;
        case (step_reg[2:0])
            3'd0: begin
                iss_term = 2'd0; acc_en = 1'b0;
            end
            3'd1: begin
                iss_term = 2'd1; acc_term = 2'd0;
            end
            3'd2: begin
                iss_term = 2'd2; acc_term = 2'd1;
            end
            3'd3: begin
                iss_term = 2'd0; acc_term = 2'd2; sq_src = magb_reg;
            end
            3'd4: begin
                iss_term = 2'd1; acc_term = 2'd0; sq_src = magb_reg; acc_to_b = 1'b1;
            end
            3'd5: begin
                iss_term = 2'd2; acc_term = 2'd1; sq_src = magb_reg; acc_to_b = 1'b1;
            end
            default: begin
                iss_term = 2'd2; acc_term = 2'd2; sq_src = magb_reg; acc_to_b = 1'b1;
            end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == cbw_pkg::ST_YMUL) begin
            mul_a = (step_reg[1:0] == 2'd0) ? 32'(row_reg) : 32'(col_reg);
            mul_b = rd_mag;
        end else if (state_reg == cbw_pkg::ST_SQ) begin
            case (iss_term)
                2'd0: begin
                    mul_a = 32'(sq_src[47:32]); mul_b = 32'(sq_src[47:32]);
                end
                2'd1: begin
                    mul_a = 32'(sq_src[47:32]); mul_b = sq_src[31:0];
                end
                default: begin
                    mul_a = sq_src[31:0]; mul_b = sq_src[31:0];
                end
            endcase
        end
    end

    cbw_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Signed position term and squared-length term from the product.
    logic signed [cbw_pkg::MAG_W-1:0] p_term, d_ext, s_ext, diff_a, diff_b;
    logic [cbw_pkg::ACC_W-1:0] sq_term;

    assign p_term = sign_reg ? -$signed(prod[47:0]) : $signed(prod[47:0]);
    assign d_ext  = {{16{dval_reg[31]}}, dval_reg};
    assign s_ext  = {{16{rd_data[31]}}, rd_data};
    assign diff_a = d_ext - s_ext;
    assign diff_b = yacc_reg - s_ext;

    always_comb begin
        case (acc_term)
            2'd0:    sq_term = {prod[31:0], 64'd0};
            2'd1:    sq_term = {prod[62:0], 33'd0};
            default: sq_term = {32'd0, prod};
        endcase
    end

    // Shared wide compare-subtract used by the check, divider and root.
    logic [cbw_pkg::REM_W-1:0] sub_x, sub_y, sub_d;
    logic [cbw_pkg::REM_W:0]   sub_full;
    logic                      sub_ge;
    logic [cbw_pkg::QUO_W-1:0] root_try;

    assign root_try = res_reg | bit_reg;

    always_comb begin
        case (state_reg)
            cbw_pkg::ST_CHECK: begin
                sub_x = cbw_pkg::REM_W'(a_reg);
                sub_y = {b_reg, 4'd0};
            end
            cbw_pkg::ST_DIV: begin
                sub_x = {rem_reg[cbw_pkg::REM_W-2:0], 1'b0};
                sub_y = den_reg;
            end
            cbw_pkg::ST_SQRT: begin
                sub_x = cbw_pkg::REM_W'(quo_reg);
                sub_y = cbw_pkg::REM_W'(root_try);
            end
            default: begin
                sub_x = '0;
                sub_y = '0;
            end
        endcase
        sub_full = {1'b0, sub_x} - {1'b0, sub_y};
        sub_ge   = !sub_full[cbw_pkg::REM_W];
        sub_d    = sub_full[cbw_pkg::REM_W-1:0];
    end

    logic [cbw_pkg::QUO_W-1:0] res_step;
    assign res_step = sub_ge ? ((res_reg >> 1) | bit_reg) : (res_reg >> 1);

    // Control sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cbw_pkg::ST_IDLE;
            step_reg     <= '0;
            axis_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            det_rows_reg <= cbw_pkg::DET_W'(1);
            det_cols_reg <= cbw_pkg::DET_W'(1);
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == cbw_pkg::CFG_DET_ROWS) begin
                    det_rows_reg <= cfg_data;
                end else if (cfg_index == cbw_pkg::CFG_DET_COLS) begin
                    det_cols_reg <= cfg_data;
                end
            end

            // The finish state reloads the output register itself.
            if (m_tvalid_reg && m_tready && (state_reg != cbw_pkg::ST_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                cbw_pkg::ST_IDLE: begin
                    if (s_acc && (in_act == cbw_pkg::ACT_PIXEL)) begin
                        row_reg  <= in_row;
                        col_reg  <= in_col;
                        step_reg <= '0;
                        axis_reg <= '0;
                        a_reg    <= '0;
                        b_reg    <= '0;
                        if (out_rng) begin
                            rwt_reg   <= '0;
                            rsat_reg  <= 1'b0;
                            roor_reg  <= 1'b1;
                            state_reg <= cbw_pkg::ST_FINISH;
                        end else begin
                            state_reg <= cbw_pkg::ST_YMUL;
                        end
                    end
                end
                cbw_pkg::ST_YMUL: begin
                    case (step_reg[1:0])
                        2'd0: begin
                            sign_reg <= rd_data[31];
                            step_reg <= step_reg + 6'd1;
                        end
                        2'd1: begin
                            yacc_reg <= p_term;
                            sign_reg <= rd_data[31];
                            step_reg <= step_reg + 6'd1;
                        end
                        2'd2: begin
                            yacc_reg <= yacc_reg + p_term + s_ext;
                            dval_reg <= rd_data;
                            step_reg <= step_reg + 6'd1;
                        end
                        default: begin
                            maga_reg  <= diff_a[47] ? 48'(-diff_a) : 48'(diff_a);
                            magb_reg  <= diff_b[47] ? 48'(-diff_b) : 48'(diff_b);
                            step_reg  <= '0;
                            state_reg <= cbw_pkg::ST_SQ;
                        end
                    endcase
                end
                cbw_pkg::ST_SQ: begin
                    if (acc_en) begin
                        if (acc_to_b) begin
                            b_reg <= b_reg + sq_term;
                        end else begin
                            a_reg <= a_reg + sq_term;
                        end
                    end
                    if (step_reg == 6'd6) begin
                        step_reg <= '0;
                        if (axis_reg == 2'd2) begin
                            state_reg <= cbw_pkg::ST_CHECK;
                        end else begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= cbw_pkg::ST_YMUL;
                        end
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                cbw_pkg::ST_CHECK: begin
                    // Zero ray length or a ratio of four or more saturates.
                    if ((b_reg == '0) || sub_ge) begin
                        rwt_reg   <= '1;
                        rsat_reg  <= 1'b1;
                        roor_reg  <= 1'b0;
                        state_reg <= cbw_pkg::ST_FINISH;
                    end else begin
                        rem_reg   <= cbw_pkg::REM_W'(a_reg);
                        den_reg   <= {b_reg, 4'd0};
                        quo_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= cbw_pkg::ST_DIV;
                    end
                end
                cbw_pkg::ST_DIV: begin
                    rem_reg <= sub_ge ? sub_d : sub_x;
                    quo_reg <= {quo_reg[cbw_pkg::QUO_W-2:0], sub_ge};
                    if (step_reg == 6'(cbw_pkg::DIV_STEPS - 1)) begin
                        res_reg   <= '0;
                        bit_reg   <= cbw_pkg::QUO_W'(1) << 62;
                        step_reg  <= '0;
                        state_reg <= cbw_pkg::ST_SQRT;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                cbw_pkg::ST_SQRT: begin
                    if (sub_ge) begin
                        quo_reg <= sub_d[cbw_pkg::QUO_W-1:0];
                    end
                    res_reg <= res_step;
                    bit_reg <= bit_reg >> 2;
                    if (step_reg == 6'(cbw_pkg::SQRT_STEPS - 1)) begin
                        rwt_reg   <= res_step[31:0];
                        rsat_reg  <= 1'b0;
                        roor_reg  <= 1'b0;
                        state_reg <= cbw_pkg::ST_FINISH;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                cbw_pkg::ST_FINISH: begin
                    // Hand over once the output register is free.
                    if (!m_tvalid_reg || m_tready) begin
                        wt_reg       <= rwt_reg;
                        sat_reg      <= rsat_reg;
                        oor_reg      <= roor_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= cbw_pkg::ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= cbw_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = wt_reg;
    assign m_tuser  = {oor_reg, sat_reg};

endmodule
